// ===== rtl/core/signed_joint_angle_between_frames_macros.svh =====
// ----------------------------------------------------------------------------
// Signed joint angle assertion macros
// Shared concurrent assertion forms for the joint angle block.
// ----------------------------------------------------------------------------
`ifndef SIGNED_JOINT_ANGLE_BETWEEN_FRAMES_MACROS_SVH
`define SIGNED_JOINT_ANGLE_BETWEEN_FRAMES_MACROS_SVH

// same-cycle implication
`define SJA_ASSERT_SAME(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("joint angle check failed");

// next-cycle implication
`define SJA_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("joint angle check failed");

`endif

// ===== rtl/core/sja_pkg.sv =====
// ----------------------------------------------------------------------------
// Joint angle package
// Types, constants, microcode and angle table for the joint angle block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sja_pkg;

  localparam int CW          = 16;
  localparam int AFB         = 13;
  localparam int CORDIC_ITER = 16;
  localparam int ITER        = (CORDIC_ITER > 32) ? 32 : CORDIC_ITER;
  localparam int ITW         = (ITER > 1) ? $clog2(ITER) : 1;
  localparam int FRAC        = CW - 2;
  localparam int ACC_W       = CW + 6;
  localparam int COR_W       = CW + 8;
  localparam int ANG_W       = 35;
  localparam int GAIN_W      = 31;
  localparam int OUT_W       = 16;
  localparam int PC_W        = 5;

  localparam logic [GAIN_W-1:0]      INV_GAIN = 31'd652032874;
  localparam logic signed [ANG_W-1:0] PI_Q30  = 35'sd3373259426;

  localparam logic [2:0] SLOT_NORMAL = 3'd6;

  localparam logic [PC_W-1:0] PC_SUM_LAST = 5'd5;
  localparam logic [PC_W-1:0] PC_AB_FIRST = 5'd6;
  localparam logic [PC_W-1:0] PC_AB_LAST  = 5'd17;
  localparam logic [PC_W-1:0] PC_C_FIRST  = 5'd18;
  localparam logic [PC_W-1:0] PC_C_LAST   = 5'd29;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM, ST_PICK, ST_CROSS_AB, ST_ZCHK, ST_CROSS_C,
    ST_CLOAD, ST_CITER, ST_CGAIN, ST_FINISH
  } state_t;

  typedef enum logic [2:0] {V_N, V_A, V_B, V_P0, V_P1, V_C} vsel_t;

  typedef enum logic [2:0] {D_S, D_P0, D_P1, D_C, D_D, D_E} dest_t;

  typedef enum logic [1:0] {J_MAG1, J_MAG2, J_ANG} job_t;

  typedef struct packed {
    vsel_t      va;
    logic [1:0] ia;
    vsel_t      vb;
    logic [1:0] ib;
    logic       sub;
    logic       first;
    logic       last;
    dest_t      dest;
    logic [1:0] oi;
  } mstep_t;

  typedef struct packed {
    logic            load_vec;
    logic            load_n;
    logic            mac;
    logic [PC_W-1:0] pc;
    logic            axis_set;
    logic [1:0]      axis_val;
    logic            axis_pick;
    logic            cor_load;
    job_t            job;
    logic            cor_step;
    logic [ITW-1:0]  iter;
    logic            gain;
    logic            out_angle;
    logic            out_zero;
  } cmd_t;

  typedef struct packed {
    logic plane_zero;
  } stat_t;

  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] r;
    unique case (i)
      5'd0:  r = 31'd843314857;
      5'd1:  r = 31'd497837830;
      5'd2:  r = 31'd263043837;
      5'd3:  r = 31'd133525159;
      5'd4:  r = 31'd67021687;
      5'd5:  r = 31'd33543516;
      5'd6:  r = 31'd16775851;
      5'd7:  r = 31'd8388437;
      5'd8:  r = 31'd4194283;
      5'd9:  r = 31'd2097149;
      5'd10: r = 31'd1048576;
      5'd11: r = 31'd524288;
      5'd12: r = 31'd262144;
      5'd13: r = 31'd131072;
      5'd14: r = 31'd65536;
      5'd15: r = 31'd32768;
      5'd16: r = 31'd16384;
      5'd17: r = 31'd8192;
      5'd18: r = 31'd4096;
      5'd19: r = 31'd2048;
      5'd20: r = 31'd1024;
      5'd21: r = 31'd512;
      5'd22: r = 31'd256;
      5'd23: r = 31'd128;
      5'd24: r = 31'd64;
      5'd25: r = 31'd32;
      5'd26: r = 31'd16;
      5'd27: r = 31'd8;
      5'd28: r = 31'd4;
      5'd29: r = 31'd2;
      5'd30: r = 31'd1;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

  function automatic mstep_t mk(input vsel_t va, input logic [1:0] ia,
                                input vsel_t vb, input logic [1:0] ib,
                                input logic sub, input logic first,
                                input logic last, input dest_t dest,
                                input logic [1:0] oi);
    mstep_t m;
    m.va = va; m.ia = ia; m.vb = vb; m.ib = ib;
    m.sub = sub; m.first = first; m.last = last; m.dest = dest; m.oi = oi;
    return m;
  endfunction

  function automatic mstep_t cross_step(input logic [2:0] k, input vsel_t a,
                                        input vsel_t b, input dest_t d);
    mstep_t m;
    unique case (k)
      3'd0:    m = mk(a, 2'd1, b, 2'd2, 1'b0, 1'b1, 1'b0, d, 2'd0);
      3'd1:    m = mk(a, 2'd2, b, 2'd1, 1'b1, 1'b0, 1'b1, d, 2'd0);
      3'd2:    m = mk(a, 2'd2, b, 2'd0, 1'b0, 1'b1, 1'b0, d, 2'd1);
      3'd3:    m = mk(a, 2'd0, b, 2'd2, 1'b1, 1'b0, 1'b1, d, 2'd1);
      3'd4:    m = mk(a, 2'd0, b, 2'd1, 1'b0, 1'b1, 1'b0, d, 2'd2);
      default: m = mk(a, 2'd1, b, 2'd0, 1'b1, 1'b0, 1'b1, d, 2'd2);
    endcase
    return m;
  endfunction

  function automatic mstep_t dot_step(input logic [1:0] k, input vsel_t a,
                                      input vsel_t b, input dest_t d);
    return mk(a, k, b, k, 1'b0, k == 2'd0, k == 2'd2, d, 2'd0);
  endfunction

  function automatic mstep_t micro(input logic [PC_W-1:0] pc);
    mstep_t     m;
    logic [1:0] i;
    if (pc <= PC_SUM_LAST) begin
      i = (pc < 5'd3) ? pc[1:0] : 2'(pc - 5'd3);
      m = mk((pc < 5'd3) ? V_A : V_B, i, V_N, i, 1'b0, pc == 5'd0,
             pc == PC_SUM_LAST, D_S, 2'd0);
    end else if (pc <= 5'd11) begin
      m = cross_step(3'(pc - 5'd6), V_N, V_A, D_P0);
    end else if (pc <= PC_AB_LAST) begin
      m = cross_step(3'(pc - 5'd12), V_N, V_B, D_P1);
    end else if (pc <= 5'd23) begin
      m = cross_step(3'(pc - 5'd18), V_P0, V_P1, D_C);
    end else if (pc <= 5'd26) begin
      m = dot_step(2'(pc - 5'd24), V_P0, V_P1, D_D);
    end else begin
      m = dot_step(2'(pc - 5'd27), V_N, V_C, D_E);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sja_ctrl.sv =====
// ----------------------------------------------------------------------------
// Joint angle controller
// Sequences the multiply-accumulate microcode and the shared CORDIC jobs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sja_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [2:0]   slot,
  input  wire sja_pkg::stat_t st,
  output sja_pkg::cmd_t     cmd,
  output logic              busy
);
  import sja_pkg::*;

  state_t          state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  logic [1:0]      ax, ax_next;
  logic [ITW-1:0]  it, it_next;
  job_t            job, job_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
      ax    <= '0;
      it    <= '0;
      job   <= J_MAG1;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      ax    <= ax_next;
      it    <= it_next;
      job   <= job_next;
    end
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    ax_next    = ax;
    it_next    = it;
    job_next   = job;
    cmd        = '0;
    cmd.pc     = pc;
    cmd.job    = job;
    cmd.iter   = it;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (slot < SLOT_NORMAL) begin
            cmd.load_vec = 1'b1;
          end else if (slot == SLOT_NORMAL) begin
            cmd.load_n = 1'b1;
            pc_next    = '0;
            ax_next    = '0;
            state_next = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        cmd.mac      = 1'b1;
        cmd.axis_set = 1'b1;
        cmd.axis_val = ax;
        if (pc == PC_SUM_LAST) begin
          pc_next = '0;
          if (ax == 2'd2) begin
            state_next = ST_PICK;
          end else begin
            ax_next = ax + 2'd1;
          end
        end else begin
          pc_next = pc + 5'd1;
        end
      end
      ST_PICK: begin
        cmd.axis_pick = 1'b1;
        pc_next       = PC_AB_FIRST;
        state_next    = ST_CROSS_AB;
      end
      ST_CROSS_AB: begin
        cmd.mac = 1'b1;
        if (pc == PC_AB_LAST) begin
          state_next = ST_ZCHK;
        end else begin
          pc_next = pc + 5'd1;
        end
      end
      ST_ZCHK: begin
        if (st.plane_zero) begin
          cmd.out_zero = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          pc_next    = PC_C_FIRST;
          state_next = ST_CROSS_C;
        end
      end
      ST_CROSS_C: begin
        cmd.mac = 1'b1;
        if (pc == PC_C_LAST) begin
          job_next   = J_MAG1;
          state_next = ST_CLOAD;
        end else begin
          pc_next = pc + 5'd1;
        end
      end
      ST_CLOAD: begin
        cmd.cor_load = 1'b1;
        it_next      = '0;
        state_next   = ST_CITER;
      end
      ST_CITER: begin
        cmd.cor_step = 1'b1;
        if (it == ITW'(ITER - 1)) begin
          it_next    = '0;
          state_next = (job == J_ANG) ? ST_FINISH : ST_CGAIN;
        end else begin
          it_next = it + 1'b1;
        end
      end
      ST_CGAIN: begin
        cmd.gain   = 1'b1;
        job_next   = (job == J_MAG1) ? J_MAG2 : J_ANG;
        state_next = ST_CLOAD;
      end
      ST_FINISH: begin
        cmd.out_angle = 1'b1;
        state_next    = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/sja_dp.sv =====
// ----------------------------------------------------------------------------
// Joint angle datapath
// Vector store, shared multiply-accumulate, CORDIC stage and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sja_dp (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [2:0]               slot,
  input  wire logic signed [sja_pkg::CW-1:0] comp_x,
  input  wire logic signed [sja_pkg::CW-1:0] comp_y,
  input  wire logic signed [sja_pkg::CW-1:0] comp_z,
  input  wire sja_pkg::cmd_t            cmd,
  output sja_pkg::stat_t                st,
  output logic signed [sja_pkg::OUT_W-1:0] joint_angle,
  output logic [1:0]                    axis_chosen,
  output logic                          done
);
  import sja_pkg::*;

  localparam logic signed [ACC_W-1:0] CMAX = ACC_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] CMIN = -CMAX - ACC_W'(1);
  localparam logic signed [ANG_W-1:0] RND  = ANG_W'(1) <<< (29 - AFB);
  localparam logic signed [ANG_W-1:0] OMAX = ANG_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [ANG_W-1:0] OMIN = -OMAX - ANG_W'(1);

  logic signed [CW-1:0]    vec [18];
  logic signed [CW-1:0]    nv [3];
  logic signed [CW-1:0]    p0 [3];
  logic signed [CW-1:0]    p1 [3];
  logic signed [CW-1:0]    cv [3];
  logic signed [ACC_W-1:0] s [3];
  logic signed [ACC_W-1:0] acc, dacc, eacc;
  logic [1:0]              axis;
  logic signed [COR_W-1:0] cx, cy, mreg;
  logic signed [ANG_W-1:0] cz;
  logic                    dneg;

  mstep_t                  ms;
  logic [1:0]              axis_eff, pick;
  logic [4:0]              vidx, slot_base;
  vsel_t                   vs;
  logic [1:0]              vi;
  logic signed [CW-1:0]    vrd, opa, opb, satv;
  logic signed [2*CW-1:0]  prod;
  logic signed [ACC_W-1:0] term, accn;
  logic signed [COR_W-1:0] xs, ys, ce0, ce1, ce2, dext;
  logic signed [ANG_W-1:0] at, zf, zr, q, qn;
  logic signed [COR_W+GAIN_W:0] gp;

  assign ms       = micro(cmd.pc);
  assign axis_eff = cmd.axis_set ? cmd.axis_val : axis;

  always_comb begin
    if (ms.va == V_A || ms.va == V_B) begin
      vs = ms.va;
      vi = ms.ia;
    end else begin
      vs = ms.vb;
      vi = ms.ib;
    end
    vidx = ((vs == V_B) ? 5'd9 : 5'd0) + 5'({axis_eff, 1'b0}) + 5'(axis_eff)
           + 5'(vi);
    vrd  = vec[vidx];
  end

  always_comb begin
    unique case (ms.va)
      V_N:      opa = nv[ms.ia];
      V_A, V_B: opa = vrd;
      V_P0:     opa = p0[ms.ia];
      V_P1:     opa = p1[ms.ia];
      V_C:      opa = cv[ms.ia];
      default:  opa = '0;
    endcase
    unique case (ms.vb)
      V_N:      opb = nv[ms.ib];
      V_A, V_B: opb = vrd;
      V_P0:     opb = p0[ms.ib];
      V_P1:     opb = p1[ms.ib];
      V_C:      opb = cv[ms.ib];
      default:  opb = '0;
    endcase
  end

  always_comb begin
    prod = opa * opb;
    term = ACC_W'(prod >>> FRAC);
    accn = (ms.first ? ACC_W'(0) : acc) + (ms.sub ? -term : term);
    if (accn > CMAX) begin
      satv = CMAX[CW-1:0];
    end else if (accn < CMIN) begin
      satv = CMIN[CW-1:0];
    end else begin
      satv = accn[CW-1:0];
    end
  end

  always_comb begin
    if (s[0] < s[1] && s[0] < s[2]) begin
      pick = 2'd0;
    end else if (s[1] < s[0] && s[1] < s[2]) begin
      pick = 2'd1;
    end else begin
      pick = 2'd2;
    end
  end

  assign st.plane_zero = (p0[0] == '0 && p0[1] == '0 && p0[2] == '0) ||
                         (p1[0] == '0 && p1[1] == '0 && p1[2] == '0);

  assign slot_base = 5'({slot, 1'b0}) + 5'(slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 18; k++) begin
        vec[k] <= '0;
      end
    end else if (cmd.load_vec) begin
      vec[slot_base]         <= comp_x;
      vec[slot_base + 5'd1]  <= comp_y;
      vec[slot_base + 5'd2]  <= comp_z;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_n) begin
      nv[0] <= comp_x;
      nv[1] <= comp_y;
      nv[2] <= comp_z;
    end
    if (cmd.axis_set) begin
      axis <= cmd.axis_val;
    end else if (cmd.axis_pick) begin
      axis <= pick;
    end
    if (cmd.mac) begin
      acc <= accn;
      if (ms.last) begin
        unique case (ms.dest)
          D_S:     s[axis_eff] <= accn;
          D_P0:    p0[ms.oi]   <= satv;
          D_P1:    p1[ms.oi]   <= satv;
          D_C:     cv[ms.oi]   <= satv;
          D_D:     dacc        <= accn;
          D_E:     eacc        <= accn;
          default: ;
        endcase
      end
    end
  end

  // CORDIC vectoring stage, one iteration per cycle
  always_comb begin
    ce0  = COR_W'(cv[0]);
    ce1  = COR_W'(cv[1]);
    ce2  = COR_W'(cv[2]);
    dext = COR_W'(dacc);
    xs   = cx >>> cmd.iter;
    ys   = cy >>> cmd.iter;
    at   = ANG_W'(atan_q30(5'(cmd.iter)));
    gp   = cx * $signed({1'b0, INV_GAIN});
  end

  always_ff @(posedge clk) begin
    if (cmd.cor_load) begin
      cz <= '0;
      unique case (cmd.job)
        J_MAG1: begin
          cx <= (ce0 < 0) ? -ce0 : ce0;
          cy <= ce1;
        end
        J_MAG2: begin
          cx <= mreg;
          cy <= ce2;
        end
        default: begin
          cx   <= (dext < 0) ? -dext : dext;
          cy   <= mreg;
          dneg <= dacc < 0;
        end
      endcase
    end else if (cmd.cor_step) begin
      if (!cy[COR_W-1]) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + at;
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - at;
      end
    end
    if (cmd.gain) begin
      mreg <= COR_W'(gp >>> 30);
    end
  end

  always_comb begin
    zf = dneg ? PI_Q30 - cz : cz;
    zr = zf + RND;
    q  = zr >>> (30 - AFB);
    qn = (eacc < 0) ? -q : q;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_angle) begin
      axis_chosen <= axis;
      if (qn > OMAX) begin
        joint_angle <= OMAX[OUT_W-1:0];
      end else if (qn < OMIN) begin
        joint_angle <= OMIN[OUT_W-1:0];
      end else begin
        joint_angle <= qn[OUT_W-1:0];
      end
    end else if (cmd.out_zero) begin
      axis_chosen <= axis;
      joint_angle <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.out_angle | cmd.out_zero;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/signed_joint_angle_between_frames.sv =====
// ----------------------------------------------------------------------------
// Signed joint angle between frames
// Top level: controller and datapath for the signed angle about a normal.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Slots 0 to 5
// store one axis vector and leave busy low; slot 7 is dropped. A slot 6
// transaction (the normal) raises busy and runs the computation on one
// shared 16x16 multiply-accumulate unit and one CORDIC stage, and ends
// early when a plane normal is zero. The result then shows on joint_angle
// and axis_chosen for exactly one cycle with done high; there is no
// back-pressure, so the receiver must capture it in that cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "signed_joint_angle_between_frames_macros.svh"

module signed_joint_angle_between_frames (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [2:0]                     slot,
  input  wire logic signed [sja_pkg::CW-1:0]  comp_x,
  input  wire logic signed [sja_pkg::CW-1:0]  comp_y,
  input  wire logic signed [sja_pkg::CW-1:0]  comp_z,
  output logic                                done,
  output logic signed [sja_pkg::OUT_W-1:0]    joint_angle,
  output logic [1:0]                          axis_chosen
);
  import sja_pkg::*;

  cmd_t  cmd;
  stat_t st;

  sja_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .slot  (slot),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  sja_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .slot        (slot),
    .comp_x      (comp_x),
    .comp_y      (comp_y),
    .comp_z      (comp_z),
    .cmd         (cmd),
    .st          (st),
    .joint_angle (joint_angle),
    .axis_chosen (axis_chosen),
    .done        (done)
  );

  `SJA_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `SJA_ASSERT_NEXT(a_normal_busy, clk, rst, start && !busy && slot == SLOT_NORMAL, busy)
  `SJA_ASSERT_NEXT(a_load_quiet, clk, rst, start && !busy && slot != SLOT_NORMAL, !done)
  `SJA_ASSERT_SAME(a_axis_legal, clk, rst, done, axis_chosen != 2'd3)

endmodule

`default_nettype wire
